>>> rtl/lism_pkg.sv
`timescale 1ns / 1ps

package lism_pkg;

	// Signature table geometry
	localparam int SIG_TABLE_LEN = 24;
	localparam int SIG_CHARS     = 11;
	localparam int SIG_IDX_W     = 5;
	localparam int COUNT_W       = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;
	localparam logic [COUNT_W-1:0] SCAN_LIMIT_RESET = 16'd4096;
	localparam logic [7:0]         CASE_FOLD_BIT    = 8'h20;

	// Register indexes
	localparam logic [0:0] REG_SCAN_LIMIT = 1'b0;

	// Match classes
	localparam logic [1:0] CLASS_NONE = 2'd0;

	typedef logic [SIG_IDX_W-1:0] sig_idx_t;

	// Best hit of one byte step
	typedef struct packed {
		logic                hit;
		sig_idx_t            idx;
		logic [COUNT_W-1:0]  start;
	} match_t;

	// Signature text, right-justified: the last character sits in the low byte,
	// so byte j lines up with the window byte j steps back from the newest.
	// Entries are already cut to their compare length.
	localparam logic [8*SIG_CHARS-1:0] SIG_TEXT [SIG_TABLE_LEN] = '{
		"${jndi:",
		"jndi:",
		"jndi:ldap:",
		"jndi:rmi:",
		"jndi:ldaps:",
		"jndi:dns:",
		"jndi:nis:",
		"jndi:iiop:",
		"jndi:nds:",
		"jndi:corba:",
		"jndi:http:",
		"${lower:",
		"${upper:",
		"${env:",
		"${sys:",
		"${java:",
		"${date:",
		"${ctx:",
		"${main:",
		88'h24_7b_6c_6f_67_34_6a,
		"${::-",
		"${hostnam",
		88'h24_7b_64_6f_63_6b_65_72_3a,
		"${k8s"
	};

	localparam logic [3:0] SIG_LEN [SIG_TABLE_LEN] = '{
		4'd7, 4'd5, 4'd10, 4'd9, 4'd11, 4'd9, 4'd9, 4'd10, 4'd9, 4'd11, 4'd10,
		4'd8, 4'd8, 4'd6, 4'd6, 4'd7, 4'd7, 4'd6, 4'd7, 4'd7,
		4'd5, 4'd9, 4'd9, 4'd5
	};

	localparam logic [1:0] SIG_CLASS [SIG_TABLE_LEN] = '{
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd3, 2'd3
	};

	// Hits of one step all end at the same byte: longer length means earlier
	// start. Rank by length descending, then index ascending.
	localparam sig_idx_t SIG_RANK [SIG_TABLE_LEN] = '{
		5'd4,  5'd9,
		5'd2,  5'd7,  5'd10,
		5'd3,  5'd5,  5'd6,  5'd8,  5'd21, 5'd22,
		5'd11, 5'd12,
		5'd0,  5'd15, 5'd16, 5'd18, 5'd19,
		5'd13, 5'd14, 5'd17,
		5'd1,  5'd20, 5'd23
	};

	// Fold A-Z to lower case
	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b | CASE_FOLD_BIT;
		end
		return r;
	endfunction

endpackage

>>> rtl/lism_match.sv
`timescale 1ns / 1ps

module lism_match #(
	parameter int WINDOW_LEN = 11
) (
	input  logic [7:0]                    cur_byte,
	input  logic [7:0]                    win [WINDOW_LEN-1],
	input  logic [lism_pkg::COUNT_W-1:0]  count,
	input  logic [lism_pkg::COUNT_W-1:0]  limit,
	output lism_pkg::match_t              result
);

	logic [7:0]                          taps [WINDOW_LEN];
	logic [lism_pkg::SIG_TABLE_LEN-1:0]  hit;
	logic [lism_pkg::COUNT_W:0]          seen;
	lism_pkg::sig_idx_t                  win_idx;
	logic                                found;

	assign seen = {1'b0, count} + {{lism_pkg::COUNT_W{1'b0}}, 1'b1};

	// Line up the newest byte with the stored window
	always_comb begin
		taps[0] = cur_byte;
		for (int j = 1; j < WINDOW_LEN; j++) begin
			taps[j] = win[j-1];
		end
	end

	// Compare every signature ending at the current byte
	always_comb begin
		for (int i = 0; i < lism_pkg::SIG_TABLE_LEN; i++) begin
			hit[i] = (int'(lism_pkg::SIG_LEN[i]) <= WINDOW_LEN)
				&& (seen >= (lism_pkg::COUNT_W+1)'(lism_pkg::SIG_LEN[i]))
				&& ((seen - (lism_pkg::COUNT_W+1)'(lism_pkg::SIG_LEN[i]))
					< {1'b0, limit});
			for (int j = 0; j < lism_pkg::SIG_CHARS; j++) begin
				if (j < int'(lism_pkg::SIG_LEN[i]) && j < WINDOW_LEN) begin
					if (taps[j] != lism_pkg::SIG_TEXT[i][8*j +: 8]) begin
						hit[i] = 1'b0;
					end
				end
			end
		end
	end

	// Pick the highest-ranked hit
	always_comb begin
		found   = 1'b0;
		win_idx = '0;
		for (int r = 0; r < lism_pkg::SIG_TABLE_LEN; r++) begin
			if (!found && hit[lism_pkg::SIG_RANK[r]]) begin
				found   = 1'b1;
				win_idx = lism_pkg::SIG_RANK[r];
			end
		end
	end

	assign result.hit   = found;
	assign result.idx   = win_idx;
	assign result.start = lism_pkg::COUNT_W'(seen
		- (lism_pkg::COUNT_W+1)'(lism_pkg::SIG_LEN[win_idx]));

endmodule

>>> rtl/lookup_injection_signature_matcher_top.sv
`timescale 1ns / 1ps

// Case-insensitive signature matcher for directory-lookup injection text.
// Bytes of one message stream in one per cycle; each byte is compared against
// all 24 signatures at once over a window of the newest WINDOW_LEN bytes, and
// the earliest-starting match below scan_limit (lower index on a tie) is kept.
// The last byte of a message produces one result beat (class, index, start,
// or all zeros) and clears the window, byte count and best match. Throughput
// is one byte per cycle while the sink takes results. The input register takes
// a byte and, when stage 1 advances, the result register loads from the
// combinational compare, so a result beat is presented from the result register
// after its last byte has passed the input register. A result held by the
// sink stalls the byte stream. The byte count saturates at 65535. scan_limit
// sits at address 0 of the APB port and resets to 4096. The user is to write
// it only while no message is in flight; the block itself does not enforce this.
module lookup_injection_signature_matcher_top #(
	parameter int WINDOW_LEN = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// result stream
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  match_class,
	output logic [4:0]  signature_index,
	output logic [15:0] match_start,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = lism_pkg::COUNT_W;

	logic                limit_wr;
	logic [CW-1:0]       limit_q;
	logic                s1_valid;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic [7:0]          win_q [WINDOW_LEN-1];
	logic [CW-1:0]       count_q;
	logic                best_found_q;
	logic [CW-1:0]       best_start_q;
	lism_pkg::sig_idx_t  best_sig_q;
	logic                out_valid_q;
	logic [1:0]          class_q;
	lism_pkg::sig_idx_t  index_q;
	logic [CW-1:0]       start_q;
	logic                advance;
	logic                proc;
	logic [7:0]          folded;
	lism_pkg::match_t    step;
	logic                take;
	logic                new_found;
	logic [CW-1:0]       new_start;
	lism_pkg::sig_idx_t  new_sig;

	// Configuration port
	assign pready = 1'b1;
	assign limit_wr = psel && penable && pwrite && (paddr == lism_pkg::REG_SCAN_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lism_pkg::SCAN_LIMIT_RESET;
		end else if (limit_wr) begin
			limit_q <= pwdata[CW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == lism_pkg::REG_SCAN_LIMIT) begin
			prdata = {{(32-CW){1'b0}}, limit_q};
		end
	end

	// Handshake: stage 1 moves whenever the result slot is free or draining
	assign advance  = !out_valid_q || out_ready;
	assign proc     = s1_valid && advance;
	assign in_ready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Compare the byte against the window
	assign folded = lism_pkg::fold_byte(byte_s1);

	lism_match #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_match (
		.cur_byte (folded),
		.win      (win_q),
		.count    (count_q),
		.limit    (limit_q),
		.result   (step)
	);

	// Merge this step's hit with the best so far
	assign take = step.hit && (!best_found_q || step.start < best_start_q
		|| (step.start == best_start_q && step.idx < best_sig_q));
	assign new_found = best_found_q || step.hit;
	assign new_start = take ? step.start : best_start_q;
	assign new_sig   = take ? step.idx : best_sig_q;

	// Advance message state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_LEN-1; k++) begin
				win_q[k] <= '0;
			end
			count_q      <= '0;
			best_found_q <= 1'b0;
			best_start_q <= '0;
			best_sig_q   <= '0;
		end else if (proc) begin
			if (last_s1) begin
				for (int k = 0; k < WINDOW_LEN-1; k++) begin
					win_q[k] <= '0;
				end
				count_q      <= '0;
				best_found_q <= 1'b0;
				best_start_q <= '0;
				best_sig_q   <= '0;
			end else begin
				win_q[0] <= folded;
				for (int k = 1; k < WINDOW_LEN-1; k++) begin
					win_q[k] <= win_q[k-1];
				end
				if (count_q != lism_pkg::COUNT_MAX) begin
					count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
				end
				best_found_q <= new_found;
				best_start_q <= new_start;
				best_sig_q   <= new_sig;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			if (new_found) begin
				class_q <= lism_pkg::SIG_CLASS[new_sig];
				index_q <= new_sig;
				start_q <= new_start;
			end else begin
				class_q <= lism_pkg::CLASS_NONE;
				index_q <= '0;
				start_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign match_class     = class_q;
	assign signature_index = index_q;
	assign match_start     = start_q;

	// Input stalls only when both stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid && out_valid_q))
		else $error("input stalled with a free stage");

	// Last byte leaves the message state cleared
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (count_q == '0 && !best_found_q))
		else $error("message state not cleared after last byte");

	// No best match means the best fields stay zero
	a_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!best_found_q |-> (best_start_q == '0 && best_sig_q == '0))
		else $error("best fields set without a match");

	// Saturated count holds within a message
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !last_s1 && count_q == lism_pkg::COUNT_MAX)
		|=> (count_q == lism_pkg::COUNT_MAX))
		else $error("byte count wrapped");

	// A no-match result carries all zeros
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && class_q == lism_pkg::CLASS_NONE)
		|-> (index_q == '0 && start_q == '0))
		else $error("no-match result with nonzero fields");

endmodule

>>> bench/lookup_injection_signature_matcher_top_tb.sv
`timescale 1ns / 1ps

module lookup_injection_signature_matcher_top_tb;

	localparam int TAPS       = 11;
	localparam int PAT_COUNT  = 24;
	localparam int STALL_MAX  = 4000;
	localparam int SINK_HOLD  = 400;

	// Signatures, right-justified: byte j is the character j steps back from the end
	localparam logic [8*TAPS-1:0] PAT_TEXT [PAT_COUNT] = '{
		"${jndi:", "jndi:", "jndi:ldap:", "jndi:rmi:", "jndi:ldaps:", "jndi:dns:",
		"jndi:nis:", "jndi:iiop:", "jndi:nds:", "jndi:corba:", "jndi:http:",
		"${lower:", "${upper:", "${env:", "${sys:", "${java:", "${date:",
		"${ctx:", "${main:", 88'h24_7b_6c_6f_67_34_6a, "${::-", "${hostnam",
		88'h24_7b_64_6f_63_6b_65_72_3a, "${k8s"
	};
	localparam int PAT_LEN [PAT_COUNT] = '{
		7, 5, 10, 9, 11, 9, 9, 10, 9, 11, 10,
		8, 8, 6, 6, 7, 7, 6, 7, 7,
		5, 9, 9, 5
	};
	localparam logic [1:0] PAT_CLASS [PAT_COUNT] = '{
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd3, 2'd3
	};

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
	} beat_t;

	typedef struct packed {
		logic [1:0]  cls;
		logic [4:0]  sig;
		logic [15:0] first;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  match_class;
	logic [4:0]  signature_index;
	logic [15:0] match_start;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [0:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Stimulus and expectation stores
	beat_t       pending_bytes [$];
	verdict_t    expected_verdicts [$];
	logic [7:0]  msg_buf [$];

	// Predictor state
	logic [15:0] scan_copy = lism_pkg::SCAN_LIMIT_RESET;
	logic [7:0]  hist [TAPS-1];
	logic [15:0] msg_count = '0;
	logic        best_hit = 1'b0;
	logic [15:0] best_first = '0;
	logic [4:0]  best_sig = '0;

	// Handshake bookkeeping
	logic        byte_taken = 1'b0;
	logic        idle_en = 1'b0;
	logic        sink_hold_req = 1'b0;
	logic        sink_hold_done = 1'b0;
	int          src_gap = 0;
	int          sink_gap = 0;
	int          hold_left = 0;
	int          stall_cycles = 0;
	int          mismatch_count = 0;
	beat_t       next_beat;
	verdict_t    want;

	lookup_injection_signature_matcher_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.match_class(match_class),
		.signature_index(signature_index),
		.match_start(match_start),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		for (int j = 0; j < TAPS - 1; j++) hist[j] = '0;
	end

	// Fold one byte into the window, score every signature ending here,
	// and on the last byte queue the verdict and clear the message state
	task automatic track_signature_hits(input logic [7:0] raw, input logic fin);
		logic [7:0]  cur;
		logic [7:0]  look [TAPS];
		logic [16:0] seen;
		logic [16:0] first;
		logic        hit;
		verdict_t    v;
		cur = raw;
		if (raw >= 8'h41 && raw <= 8'h5A) cur = raw | lism_pkg::CASE_FOLD_BIT;
		look[0] = cur;
		for (int j = 1; j < TAPS; j++) look[j] = hist[j-1];
		seen = {1'b0, msg_count} + 17'd1;
		for (int s = 0; s < PAT_COUNT; s++) begin
			hit = (seen >= PAT_LEN[s]);
			for (int j = 0; j < PAT_LEN[s]; j++) begin
				if (look[j] != PAT_TEXT[s][8*j +: 8]) hit = 1'b0;
			end
			first = 17'(seen - PAT_LEN[s]);
			if (hit && first < {1'b0, scan_copy} &&
				(!best_hit || first[15:0] < best_first ||
				(first[15:0] == best_first && s < best_sig))) begin
				best_hit = 1'b1;
				best_first = first[15:0];
				best_sig = s[4:0];
			end
		end
		for (int j = TAPS - 2; j > 0; j--) hist[j] = hist[j-1];
		hist[0] = cur;
		if (msg_count != lism_pkg::COUNT_MAX) msg_count = msg_count + 16'd1;
		if (fin) begin
			if (best_hit) begin
				v.cls = PAT_CLASS[best_sig];
				v.sig = best_sig;
				v.first = best_first;
			end else begin
				v.cls = lism_pkg::CLASS_NONE;
				v.sig = '0;
				v.first = '0;
			end
			expected_verdicts.push_back(v);
			for (int j = 0; j < TAPS - 1; j++) hist[j] = '0;
			msg_count = '0;
			best_hit = 1'b0;
			best_first = '0;
			best_sig = '0;
		end
	endtask

	// Move the scratch message into the send queue, last byte flagged
	task automatic commit_message();
		beat_t bt;
		for (int k = 0; k < msg_buf.size(); k++) begin
			bt.b = msg_buf[k];
			bt.fin = (k == msg_buf.size() - 1);
			pending_bytes.push_back(bt);
		end
		msg_buf.delete();
	endtask

	task automatic queue_text(input string s);
		for (int k = 0; k < s.len(); k++) msg_buf.push_back(s[k]);
		commit_message();
	endtask

	// Random message: either noise, or filler around one or two signatures
	// with random case and an occasional corrupted byte
	task automatic queue_message(input bit shaped, input int noise_max);
		logic [7:0] ch;
		int         s;
		if (!shaped) begin
			repeat ($urandom_range(1, noise_max))
				msg_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 6)) msg_buf.push_back(8'($urandom_range(32, 126)));
			repeat ($urandom_range(1, 2)) begin
				s = $urandom_range(0, PAT_COUNT - 1);
				for (int j = PAT_LEN[s] - 1; j >= 0; j--) begin
					ch = PAT_TEXT[s][8*j +: 8];
					if (ch >= "a" && ch <= "z" && $urandom_range(0, 2) == 0)
						ch = ch ^ lism_pkg::CASE_FOLD_BIT;
					msg_buf.push_back(ch);
				end
				if ($urandom_range(0, 4) == 0)
					msg_buf[$urandom_range(0, msg_buf.size() - 1)] =
						8'($urandom_range(0, 255));
				repeat ($urandom_range(0, 4)) msg_buf.push_back(8'($urandom_range(32, 126)));
			end
		end
		commit_message();
	endtask

	// Wait until every byte is in and every verdict is out, then let the pipe empty
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_scan_limit(input logic [15:0] lim);
		wait_drained();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= lism_pkg::REG_SCAN_LIMIT;
		pwdata <= {16'h0000, lim};
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		scan_copy = lim;
		@(posedge clk);
	endtask

	// Byte driver: hold each beat until taken, insert idle bursts
	always @(negedge clk) begin
		if (!in_valid || byte_taken) begin
			if (src_gap != 0) begin
				in_valid <= 1'b0;
				src_gap = src_gap - 1;
			end else if (pending_bytes.size() != 0 && idle_en && $urandom_range(0, 11) == 0) begin
				in_valid <= 1'b0;
				src_gap = $urandom_range(0, 8);
			end else if (pending_bytes.size() != 0) begin
				next_beat = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_beat.b;
				last_byte <= next_beat.fin;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result sink: random stall bursts and one long hold-off on request
	always @(negedge clk) begin
		if (sink_hold_req && !sink_hold_done) begin
			hold_left = SINK_HOLD;
			sink_hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (sink_gap != 0) begin
			out_ready <= 1'b0;
			sink_gap = sink_gap - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			sink_gap = $urandom_range(0, 8);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predict on each byte beat, check each result beat, watch for a hang
	always @(posedge clk) begin
		byte_taken = in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) track_signature_hits(data_byte, last_byte);
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected result class %0d sig %0d start %0d",
							$time, match_class, signature_index, match_start);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = expected_verdicts.pop_front();
					if (match_class !== want.cls || signature_index !== want.sig ||
						match_start !== want.first) begin
						if (mismatch_count < 10)
							$display("%0t: expected class %0d sig %0d start %0d, got %0d %0d %0d",
								$time, want.cls, want.sig, want.first,
								match_class, signature_index, match_start);
						mismatch_count = mismatch_count + 1;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles = stall_cycles + 1;
				if (stall_cycles >= STALL_MAX) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [15:0] lim;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		idle_en = 1'b1;

		// Directed: byte extremes, single byte, exact-length and folded matches
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'hFF);
		commit_message();
		queue_text("x");
		queue_text("jndi:");
		queue_text("${JNDI:LDAP:");
		queue_text("ab${LoWeR:");
		queue_text("${::-x");
		queue_text("`{@[Z${K8S:");
		queue_text("jndi:rmi:");

		// Tightest limit: only a match at offset zero counts
		set_scan_limit(16'd1);
		queue_text("jndi:");
		queue_text("xjndi:");

		// Zero limit rejects everything
		set_scan_limit(16'd0);
		queue_text("${jndi:");

		// Widest limit
		set_scan_limit(lism_pkg::COUNT_MAX);
		queue_text("${jndi:");

		// Random phases across several limits
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: lim = lism_pkg::SCAN_LIMIT_RESET;
				1: lim = 16'($urandom_range(1, 30));
				2: lim = 16'($urandom_range(1, 65535));
				default: lim = 16'($urandom_range(2, 12));
			endcase
			set_scan_limit(lim);
			repeat (5) queue_message($urandom_range(0, 3) != 0, 20);
		end

		// Back-pressure: short messages while results are held off
		set_scan_limit(16'd40);
		repeat (25) queue_message($urandom_range(0, 2) == 0, 3);
		sink_hold_req = 1'b1;

		// Final stretch without idling
		wait_drained();
		idle_en = 1'b0;
		set_scan_limit(lism_pkg::SCAN_LIMIT_RESET);
		repeat (5) queue_message($urandom_range(0, 3) != 0, 20);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
